[rtl/spq_pkg.sv]
package spq_pkg;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int PRIO_BITS_DEFAULT = 8;
   localparam int DATA_W            = 32;
   localparam int CSR_W             = 7;
   localparam int STATUS_W          = 2;

   localparam logic [CSR_W-1:0] CAPACITY_RESET = CSR_W'(64);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctrl_type;

endpackage

[rtl/spq_req_if.sv]
interface spq_req_if #(
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT
);
   logic                                valid;
   logic                                ready;
   logic                                cmd;
   logic signed [spq_pkg::DATA_W-1:0]   data_in;
   logic        [PRIO_BITS-1:0]         priority_in;

   modport source (output valid, cmd, data_in, priority_in, input ready);
   modport sink   (input valid, cmd, data_in, priority_in, output ready);
endinterface

[rtl/spq_rsp_if.sv]
interface spq_rsp_if #(
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT,
   parameter int CNT_W     = $clog2(spq_pkg::DEPTH_DEFAULT + 1)
);
   logic                                valid;
   logic                                ready;
   logic        [spq_pkg::STATUS_W-1:0] status;
   logic signed [spq_pkg::DATA_W-1:0]   data_out;
   logic        [PRIO_BITS-1:0]         priority_out;
   logic        [CNT_W-1:0]             count;

   modport source (output valid, status, data_out, priority_out, count, input ready);
   modport sink   (input valid, status, data_out, priority_out, count, output ready);
endinterface

[rtl/spq_cell.sv]
module spq_cell
   import spq_pkg::*;
#(
   parameter int PRIO_BITS = PRIO_BITS_DEFAULT
) (
   input  logic                        clock,
   input  cell_ctrl_type               ctrl,
   input  logic                        occupied,
   input  logic signed [DATA_W-1:0]    new_data,
   input  logic        [PRIO_BITS-1:0] new_prio,
   input  logic                        left_keep,
   input  logic signed [DATA_W-1:0]    left_data,
   input  logic        [PRIO_BITS-1:0] left_prio,
   input  logic signed [DATA_W-1:0]    right_data,
   input  logic        [PRIO_BITS-1:0] right_prio,
   output logic signed [DATA_W-1:0]    data,
   output logic        [PRIO_BITS-1:0] prio,
   output logic                        keep
);

   logic signed [DATA_W-1:0]    data_ff, data_in;
   logic        [PRIO_BITS-1:0] prio_ff, prio_in;
   logic                        outranks;

   assign outranks = (prio_ff > new_prio) ||
                     ((prio_ff == new_prio) && (data_ff < new_data));
   assign keep     = occupied && outranks;

   always_comb begin
      data_in = data_ff;
      prio_in = prio_ff;
      if (ctrl.ins && !keep) begin
         if (left_keep) begin
            data_in = new_data;
            prio_in = new_prio;
         end else begin
            data_in = left_data;
            prio_in = left_prio;
         end
      end else if (ctrl.rem) begin
         data_in = right_data;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign data = data_ff;
   assign prio = prio_ff;

endmodule

[rtl/sorted_priority_queue_core.sv]
// Bounded priority queue built as a row of DEPTH sorted cells, best entry in
// cell 0. An insert is compared against every cell at once and the worse
// entries shift one cell down; a remove shifts the whole row up one cell and
// returns cell 0. One transaction is accepted per clock unless rsp.ready holds
// back a pending response; its response is registered, appearing the cycle after
// acceptance; the cell row's compare-and-shift sets throughput. Highest priority
// wins, ties go to the smaller signed data. Inserts beyond min(capacity, DEPTH)
// answer full; removes from an empty queue answer empty. Write capacity only
// while the queue is idle. No initialization pass is needed after reset.
module sorted_priority_queue_core
   import spq_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int PRIO_BITS = PRIO_BITS_DEFAULT,
   parameter int CNT_W     = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   spq_req_if.sink          req,
   spq_rsp_if.source        rsp,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int LIM_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   logic [CSR_W-1:0]            capacity_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [LIM_W-1:0]            limit, count_ext;
   logic                        accept, full, empty;
   cell_ctrl_type               ctrl;

   logic                        keep [DEPTH];
   logic signed [DATA_W-1:0]    cdata [DEPTH];
   logic        [PRIO_BITS-1:0] cprio [DEPTH];

   logic                        rsp_valid_ff;
   logic [STATUS_W-1:0]         status_ff, status_in;
   logic signed [DATA_W-1:0]    data_out_ff, data_out_in;
   logic [PRIO_BITS-1:0]        prio_out_ff, prio_out_in;
   logic [CNT_W-1:0]            count_out_ff;

   assign accept    = req.valid && req.ready;
   assign req.ready = !rsp_valid_ff || rsp.ready;

   assign count_ext = LIM_W'(count_ff);
   assign limit     = (LIM_W'(capacity_ff) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH)
                                                            : LIM_W'(capacity_ff);
   assign full      = count_ext >= limit;
   assign empty     = count_ff == '0;

   assign ctrl.ins = accept && (req.cmd == CMD_INSERT) && !full;
   assign ctrl.rem = accept && (req.cmd == CMD_REMOVE) && !empty;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                        lk;
         logic signed [DATA_W-1:0]    ld, rd;
         logic        [PRIO_BITS-1:0] lp, rp;

         if (i == 0) begin : g_first
            assign lk = 1'b1;
            assign ld = cdata[0];
            assign lp = cprio[0];
         end else begin : g_mid
            assign lk = keep[i-1];
            assign ld = cdata[i-1];
            assign lp = cprio[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign rd = '0;
            assign rp = '0;
         end else begin : g_inner
            assign rd = cdata[i+1];
            assign rp = cprio[i+1];
         end

         spq_cell #(
            .PRIO_BITS (PRIO_BITS)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (CNT_W'(i) < count_ff),
            .new_data   (req.data_in),
            .new_prio   (req.priority_in),
            .left_keep  (lk),
            .left_data  (ld),
            .left_prio  (lp),
            .right_data (rd),
            .right_prio (rp),
            .data       (cdata[i]),
            .prio       (cprio[i]),
            .keep       (keep[i])
         );
      end
   endgenerate

   always_comb begin
      count_in    = count_ff;
      data_out_in = '0;
      prio_out_in = '0;
      if (req.cmd == CMD_INSERT) begin
         status_in = full ? ST_FULL : ST_INSERTED;
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         status_in = empty ? ST_EMPTY : ST_REMOVED;
         if (!empty) begin
            count_in    = count_ff - CNT_W'(1);
            data_out_in = cdata[0];
            prio_out_in = cprio[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         data_out_ff  <= data_out_in;
         prio_out_ff  <= prio_out_in;
         count_out_ff <= count_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.data_out     = data_out_ff;
   assign rsp.priority_out = prio_out_ff;
   assign rsp.count        = count_out_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      LIM_W'(count_ff) <= LIM_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_empty_remove: assert property (@(posedge clock) disable iff (reset)
      accept && (req.cmd == CMD_REMOVE) && empty |=> rsp.status == ST_EMPTY)
      else $error("remove from empty queue not reported empty");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      accept && (req.cmd == CMD_INSERT) && !full |=>
         count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not advance count");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      accept && (req.cmd == CMD_INSERT) && full |=> $stable(count_ff))
      else $error("dropped insert changed count");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
   import spq_pkg::*;

   localparam int PRIO_W = PRIO_BITS_DEFAULT;
   localparam int CNT_W  = $clog2(DEPTH_DEFAULT + 1);

   typedef struct {
      logic                     cmd;
      logic signed [DATA_W-1:0] data;
      logic [PRIO_W-1:0]        prio;
      bit                       drain;
   } command_type;

   typedef struct {
      logic signed [DATA_W-1:0] data;
      logic [PRIO_W-1:0]        prio;
   } entry_type;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] data;
      logic [PRIO_W-1:0]        prio;
      logic [CNT_W-1:0]         count;
   } result_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CSR_W-1:0] csr_wdata;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_priority_queue_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   command_type      pending_q[$];
   result_type       expected_rsp_q[$];
   entry_type        queue_model[$];
   logic [CSR_W-1:0] capacity_shadow = CAPACITY_RESET;
   bit               no_idle = 1'b0;
   int               cmds_issued = 0;
   int               rsps_seen = 0;
   int               errors = 0;
   int               gap_left = 0;
   int               stall_left = 0;
   int               n_inserted = 0;
   int               n_removed = 0;
   int               n_full = 0;
   int               n_empty = 0;
   int               n_settings = 0;
   command_type      next_cmd;
   result_type       want;

   function automatic bit outranks(entry_type a, entry_type b);
      if (a.prio != b.prio)
         return a.prio > b.prio;
      return a.data < b.data;
   endfunction

   function automatic int queue_limit();
      return (capacity_shadow > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(capacity_shadow);
   endfunction

   // best entry kept at the front of queue_model
   function automatic result_type apply_command(logic cmd, logic signed [DATA_W-1:0] d,
                                                logic [PRIO_W-1:0] p);
      result_type r;
      entry_type  e;
      int         pos;
      r.status = ST_INSERTED;
      r.data   = '0;
      r.prio   = '0;
      if (cmd == CMD_INSERT) begin
         if (queue_model.size() >= queue_limit()) begin
            r.status = ST_FULL;
         end else begin
            e.data = d;
            e.prio = p;
            pos = 0;
            while (pos < queue_model.size() && !outranks(e, queue_model[pos]))
               pos++;
            queue_model.insert(pos, e);
         end
      end else if (queue_model.size() == 0) begin
         r.status = ST_EMPTY;
      end else begin
         e = queue_model.pop_front();
         r.status = ST_REMOVED;
         r.data   = e.data;
         r.prio   = e.prio;
      end
      r.count = CNT_W'(queue_model.size());
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [DATA_W-1:0] random_data();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return $urandom;
      if (r < 6)
         return $signed($urandom_range(0, 4)) - 2;
      if (r == 6)
         return 32'sh8000_0000;
      if (r == 7)
         return 32'sh7FFF_FFFF;
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [PRIO_W-1:0] random_prio();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return PRIO_W'($urandom_range(0, 255));
      if (r < 8) begin
         case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            default: return 8'd255;
         endcase
      end
      return PRIO_W'($urandom_range(0, 3));
   endfunction

   task automatic add_cmd(logic c, logic signed [DATA_W-1:0] d, logic [PRIO_W-1:0] p,
                          bit drain = 1'b0);
      command_type t;
      t.cmd   = c;
      t.data  = d;
      t.prio  = p;
      t.drain = drain;
      pending_q.push_back(t);
   endtask

   task automatic wait_idle();
      do
         @(posedge clock);
      while (pending_q.size() != 0 || cmds_issued != rsps_seen);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CSR_W-1:0] v);
      wait_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      capacity_shadow = v;
      n_settings++;
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = CAPACITY_RESET;
      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_INSERT;
      req_ch.data_in     = '0;
      req_ch.priority_in = '0;
      rsp_ch.ready       = 1'b0;
      forever #2 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_rsp_q.push_back(apply_command(req_ch.cmd, req_ch.data_in,
                                                   req_ch.priority_in));
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_q.size() != 0 &&
                         !(pending_q[0].drain && cmds_issued != rsps_seen)) begin
               next_cmd = pending_q.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.cmd         <= next_cmd.cmd;
               req_ch.data_in     <= next_cmd.data;
               req_ch.priority_in <= next_cmd.prio;
               cmds_issued++;
               gap_left = no_idle ? 0 : pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsps_seen++;
            if (expected_rsp_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction status %0d data %0d prio %0d count %0d",
                        $time, rsp_ch.status, rsp_ch.data_out, rsp_ch.priority_out,
                        rsp_ch.count);
            end else begin
               want = expected_rsp_q.pop_front();
               case (want.status)
                  ST_INSERTED: n_inserted++;
                  ST_REMOVED:  n_removed++;
                  ST_FULL:     n_full++;
                  default:     n_empty++;
               endcase
               if (rsp_ch.status !== want.status || rsp_ch.data_out !== want.data ||
                   rsp_ch.priority_out !== want.prio || rsp_ch.count !== want.count) begin
                  errors++;
                  $display("%0t: mismatch, expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
                           $time, want.status, want.data, want.prio, want.count,
                           rsp_ch.status, rsp_ch.data_out, rsp_ch.priority_out,
                           rsp_ch.count);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!no_idle)
               stall_left = pick_gap();
         end
      end
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [CSR_W-1:0] caps[12];
      int               ins_pct[12];
      int               i;
      int               k;

      caps    = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd0, 7'd8, 7'd64, 7'd5, 7'd3, 7'd50, 7'd16,
                  7'd33};
      ins_pct = '{90, 50, 60, 50, 30, 70, 20, 55, 50, 65, 40, 50};
      caps[11] = CSR_W'($urandom_range(1, 64));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ordering: priority first, then smaller signed data on ties
      write_capacity(7'd64);
      add_cmd(CMD_REMOVE, 0, 0);
      add_cmd(CMD_INSERT, 32'sh7FFF_FFFF, 8'd0);
      add_cmd(CMD_INSERT, 32'sh8000_0000, 8'd0);
      add_cmd(CMD_INSERT, 0, 8'd255);
      add_cmd(CMD_INSERT, -1, 8'd255);
      add_cmd(CMD_INSERT, -1, 8'd255);
      add_cmd(CMD_INSERT, 5, 8'd128);
      repeat (7) add_cmd(CMD_REMOVE, 32'sh7FFF_FFFF, 8'd255);

      write_capacity(7'd1);
      add_cmd(CMD_INSERT, 7, 8'd9);
      add_cmd(CMD_INSERT, 8, 8'd10);
      add_cmd(CMD_REMOVE, 0, 0);
      add_cmd(CMD_REMOVE, 0, 0);

      write_capacity(7'd0);
      add_cmd(CMD_INSERT, -5, 8'd200);
      add_cmd(CMD_REMOVE, 0, 0);

      write_capacity(7'd127);
      add_cmd(CMD_INSERT, 32'shAAAA_AAAA, 8'hAA);
      add_cmd(CMD_INSERT, 32'sh5555_5555, 8'h55);
      add_cmd(CMD_REMOVE, 0, 0);
      add_cmd(CMD_REMOVE, 0, 0);

      for (i = 0; i < 12; i++) begin
         write_capacity(caps[i]);
         no_idle = (i % 4 == 2);
         for (k = 0; k < 100; k++) begin
            if ($urandom_range(0, 99) < ins_pct[i])
               add_cmd(CMD_INSERT, random_data(), random_prio(), $urandom_range(0, 149) == 0);
            else
               add_cmd(CMD_REMOVE, random_data(), random_prio(), $urandom_range(0, 149) == 0);
         end
      end
      // hold off until every response of the last phase is back
      add_cmd(CMD_REMOVE, 0, 0, 1'b1);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Ran %0d transactions over %0d capacity settings: %0d inserted, %0d removed,",
               rsps_seen, n_settings, n_inserted, n_removed);
      $display("  %0d refused as full, %0d answered empty, %0d errors",
               n_full, n_empty, errors);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
